### design/prt_pkg.sv
`timescale 1ns / 1ps
// Package for the priority record table: sizes, codes, request and result types.
// Used by prt_cell and priority_record_table_unit; depends on nothing else.
package prt_pkg;

    localparam int DEPTH   = 64;
    localparam int ID_BITS = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PORT_ID_W = 16;

    typedef enum logic [2:0] {
        ACT_ADD,
        ACT_FIND,
        ACT_SET,
        ACT_RESOLVE,
        ACT_DELETE,
        ACT_SORT,
        ACT_LIST,
        ACT_NONE
    } action_t;

    typedef enum logic [1:0] {
        RC_DONE,
        RC_MISS,
        RC_FULL,
        RC_EMPTY
    } result_code_t;

    typedef struct packed {
        action_t                action;
        logic [PORT_ID_W-1:0]   record_id;
        logic [1:0]             new_priority;
    } in_req_t;

    typedef struct packed {
        result_code_t           result_code;
        logic [PORT_ID_W-1:0]   entry_id;
        logic [1:0]             entry_priority;
        logic                   entry_resolved;
        logic                   last;
    } out_resp_t;

    typedef struct packed {
        logic [ID_BITS-1:0]     id;
        logic [1:0]             prio;
        logic                   res;
    } entry_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_SHIFT,
        CM_LOAD,
        CM_SORT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t             mode;
        logic                   sort_right;
        logic                   sort_active;
    } cell_ctl_t;

    function automatic logic [1:0] clamp_prio(input logic [1:0] p);
        return (p == 2'd0) ? 2'd3 : p;
    endfunction

    function automatic logic [ID_BITS-1:0] to_key(input logic [PORT_ID_W-1:0] v);
        logic [ID_BITS-1:0] k;
        k = '0;
        for (int b = 0; b < ID_BITS; b++)
        begin
            if (b < PORT_ID_W)
            begin
                k[b] = v[b];
            end
        end
        return k;
    endfunction

    function automatic logic [PORT_ID_W-1:0] to_port_id(input logic [ID_BITS-1:0] v);
        logic [PORT_ID_W-1:0] o;
        o = '0;
        for (int b = 0; b < PORT_ID_W; b++)
        begin
            if (b < ID_BITS)
            begin
                o[b] = v[b];
            end
        end
        return o;
    endfunction

endpackage

### design/prt_cell.sv
`timescale 1ns / 1ps
// One storage cell of the record chain: holds one record and can take a neighbor's.
// Depends on prt_pkg.
module prt_cell (
    input  logic               clk,
    input  prt_pkg::cell_ctl_t ctl,
    input  prt_pkg::entry_t    load_entry,
    input  prt_pkg::entry_t    left_entry,
    input  prt_pkg::entry_t    right_entry,
    output prt_pkg::entry_t    entry
);

    prt_pkg::entry_t entry_reg;
    prt_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.mode)
            prt_pkg::CM_HOLD:  entry_next = entry_reg;
            prt_pkg::CM_SHIFT: entry_next = right_entry;
            prt_pkg::CM_LOAD:  entry_next = load_entry;
            prt_pkg::CM_SORT:
            begin
                if (ctl.sort_active)
                begin
                    if (ctl.sort_right)
                    begin
                        if (entry_reg.prio > right_entry.prio)
                        begin
                            entry_next = right_entry;
                        end
                    end
                    else if (left_entry.prio > entry_reg.prio)
                    begin
                        entry_next = left_entry;
                    end
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### design/priority_record_table_unit.sv
`timescale 1ns / 1ps
// Priority record table: a chain of DEPTH cells that rotates through one head slot.
// Add is answered straight from idle; ignored codes get no result. Find, set, resolve
// and delete scan one full rotation of the cell chain, sort runs DEPTH transposition
// rounds and list holds its rotation while the consumer stalls; requests wait for idle.
// Reset clears the record count and the control state; record contents are not cleared.
module priority_record_table_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  prt_pkg::in_req_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output prt_pkg::out_resp_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SORT,
        ST_LIST,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    logic [prt_pkg::CNT_W-1:0]     count_reg;
    logic [prt_pkg::IDX_W-1:0]     k_reg;
    logic [prt_pkg::IDX_W-1:0]     pos_reg;
    logic                          found_reg;
    prt_pkg::entry_t               hit_reg;
    prt_pkg::in_req_t              cmd_reg;
    logic                          out_valid_reg;
    prt_pkg::out_resp_t            out_reg;

    prt_pkg::entry_t               cells [prt_pkg::DEPTH];
    prt_pkg::entry_t               head;
    prt_pkg::entry_t               tail_entry;
    prt_pkg::entry_t               new_entry;
    prt_pkg::entry_t               load_entry;
    logic [prt_pkg::ID_BITS-1:0]   key_cmd;
    logic                          slot_free;
    logic                          accept;
    logic                          k_last;
    logic                          k_in_use;
    logic                          head_match;
    logic                          rotate;
    logic                          del_shift;
    logic                          add_load;

    assign head      = cells[0];
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign key_cmd   = prt_pkg::to_key(cmd_reg.record_id);
    assign k_last    = (k_reg == prt_pkg::IDX_W'(prt_pkg::DEPTH - 1));
    assign k_in_use  = (prt_pkg::CNT_W'(k_reg) < count_reg);
    assign head_match = (state_reg == ST_SCAN) && !found_reg && k_in_use
                        && (head.id == key_cmd);
    assign rotate    = (state_reg == ST_SCAN) || ((state_reg == ST_LIST) && slot_free);
    assign del_shift = (state_reg == ST_FINISH) && slot_free && found_reg
                       && (cmd_reg.action == prt_pkg::ACT_DELETE);
    assign add_load  = accept && (in_data.action == prt_pkg::ACT_ADD)
                       && (count_reg < prt_pkg::CNT_W'(prt_pkg::DEPTH));

    always_comb
    begin
        new_entry.id   = prt_pkg::to_key(in_data.record_id);
        new_entry.prio = prt_pkg::clamp_prio(in_data.new_priority);
        new_entry.res  = 1'b0;
    end

    always_comb
    begin
        tail_entry = head;
        if (head_match)
        begin
            if (cmd_reg.action == prt_pkg::ACT_SET)
            begin
                tail_entry.prio = prt_pkg::clamp_prio(cmd_reg.new_priority);
            end
            else if (cmd_reg.action == prt_pkg::ACT_RESOLVE)
            begin
                tail_entry.res = 1'b1;
            end
        end
    end

    assign load_entry = rotate ? tail_entry : new_entry;

    for (genvar i = 0; i < prt_pkg::DEPTH; i++)
    begin : g_cell
        prt_pkg::cell_ctl_t ctl;
        prt_pkg::entry_t    left_e;
        prt_pkg::entry_t    right_e;

        assign left_e  = (i > 0) ? cells[(i > 0) ? i - 1 : 0] : cells[i];
        assign right_e = (i < prt_pkg::DEPTH - 1)
                         ? cells[(i < prt_pkg::DEPTH - 1) ? i + 1 : i] : cells[i];

        always_comb
        begin
            ctl.sort_right = (1'(i % 2) == k_reg[0]);
            if (ctl.sort_right)
            begin
                ctl.sort_active = (prt_pkg::CNT_W'(i + 1) < count_reg);
            end
            else
            begin
                ctl.sort_active = (i > 0) && (prt_pkg::CNT_W'(i) < count_reg);
            end
            if (rotate)
            begin
                ctl.mode = (i == prt_pkg::DEPTH - 1) ? prt_pkg::CM_LOAD : prt_pkg::CM_SHIFT;
            end
            else if (state_reg == ST_SORT)
            begin
                ctl.mode = prt_pkg::CM_SORT;
            end
            else if (del_shift && (prt_pkg::CNT_W'(i) >= prt_pkg::CNT_W'(pos_reg)))
            begin
                ctl.mode = prt_pkg::CM_SHIFT;
            end
            else if (add_load && (prt_pkg::CNT_W'(i) == count_reg))
            begin
                ctl.mode = prt_pkg::CM_LOAD;
            end
            else
            begin
                ctl.mode = prt_pkg::CM_HOLD;
            end
        end

        prt_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .load_entry  (load_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cells[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= in_data;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        case (in_data.action)
                            prt_pkg::ACT_ADD:
                            begin
                                out_valid_reg <= 1'b1;
                                if (add_load)
                                begin
                                    out_reg <= '{prt_pkg::RC_DONE,
                                                 prt_pkg::to_port_id(new_entry.id),
                                                 new_entry.prio, 1'b0, 1'b1};
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    out_reg <= '{prt_pkg::RC_FULL, '0, 2'd0, 1'b0, 1'b1};
                                end
                            end
                            prt_pkg::ACT_FIND, prt_pkg::ACT_SET,
                            prt_pkg::ACT_RESOLVE, prt_pkg::ACT_DELETE:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            prt_pkg::ACT_SORT:
                            begin
                                state_reg <= ST_SORT;
                            end
                            prt_pkg::ACT_LIST:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_valid_reg <= 1'b1;
                                    out_reg <= '{prt_pkg::RC_EMPTY, '0, 2'd0, 1'b0, 1'b1};
                                end
                                else
                                begin
                                    state_reg <= ST_LIST;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (head_match)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= k_reg;
                        hit_reg   <= (cmd_reg.action == prt_pkg::ACT_DELETE) ? head : tail_entry;
                    end
                    if (k_last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_SORT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (cmd_reg.action == prt_pkg::ACT_SORT)
                        begin
                            out_reg <= '{prt_pkg::RC_DONE, '0, 2'd0, 1'b0, 1'b1};
                        end
                        else if (found_reg)
                        begin
                            out_reg <= '{prt_pkg::RC_DONE, prt_pkg::to_port_id(hit_reg.id),
                                         hit_reg.prio, hit_reg.res, 1'b1};
                        end
                        else
                        begin
                            out_reg <= '{prt_pkg::RC_MISS, '0, 2'd0, 1'b0, 1'b1};
                        end
                        if (del_shift)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                ST_LIST:
                begin
                    if (slot_free)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_in_use)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg <= '{prt_pkg::RC_DONE, prt_pkg::to_port_id(head.id),
                                         head.prio, head.res,
                                         (prt_pkg::CNT_W'(k_reg) + 1'b1) == count_reg};
                        end
                        if (k_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= prt_pkg::CNT_W'(prt_pkg::DEPTH))
        else $error("record count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg))
              || (count_reg == $past(count_reg) + 1'b1)
              || (count_reg == $past(count_reg) - 1'b1))
        else $error("record count moved by more than one");

    a_not_last_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> (state_reg == ST_LIST))
        else $error("non-final result outside a list request");
`endif

endmodule
